// ===== rtl/millisecond_tick_with_periodic_slots_top_macros.svh =====
// Assertion macros shared by the checker of the millisecond tick block.
`ifndef MILLISECOND_TICK_WITH_PERIODIC_SLOTS_TOP_MACROS_SVH
`define MILLISECOND_TICK_WITH_PERIODIC_SLOTS_TOP_MACROS_SVH

// Immediate implication checked at every clock edge outside reset.
`define MSTK_ASSERT_NOW(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define MSTK_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/mstk_pkg.sv =====
// Types and constants shared by the millisecond tick block.
package mstk_pkg;

	localparam int SLOTS_DEF = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [6:0] FRACT_MOD     = 7'd125;
	localparam logic [6:0] FRACT_REG_MAX = 7'd124;
	localparam logic [3:0] WHOLE_MS_RST  = 4'd1;
	localparam logic [6:0] FRACT_RST     = 7'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WHOLE_MS = 3'd0,
		CFG_FRACT    = 3'd1,
		CFG_ENABLE   = 3'd2,
		CFG_PERIOD0  = 3'd3,
		CFG_PERIOD1  = 3'd4,
		CFG_PERIOD2  = 3'd5,
		CFG_PERIOD3  = 3'd6
	} cfg_idx_e;

	typedef enum logic {
		FUNC_TICK    = 1'b0,
		FUNC_RESTART = 1'b1
	} func_e;

	typedef struct packed {
		logic [3:0] whole_ms;
		logic [6:0] fract;
		logic [3:0] enable;
	} tick_cfg_t;

	typedef struct packed {
		logic       go;
		func_e      func;
		logic [1:0] slot;
	} step_t;

endpackage

// ===== rtl/mstk_cfg.sv =====
// Configuration register file of the millisecond tick block.
module mstk_cfg #(
	parameter int SLOTS = mstk_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mstk_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]                    wr_data,
	output mstk_pkg::tick_cfg_t            cfg,
	output logic [31:0]                    period [SLOTS]
);
	import mstk_pkg::*;

	tick_cfg_t   cfg_q;
	logic [31:0] period_q [SLOTS];
	logic [6:0]  fract_sat;

	// Fractions above the modulus minus one are clipped so one carry per tick suffices.
	assign fract_sat = (wr_data[6:0] > FRACT_REG_MAX) ? FRACT_REG_MAX : wr_data[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.whole_ms <= WHOLE_MS_RST;
			cfg_q.fract    <= FRACT_RST;
			cfg_q.enable   <= '0;
			for (int k = 0; k < SLOTS; k++) begin
				period_q[k] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == CFG_WHOLE_MS) begin
				cfg_q.whole_ms <= wr_data[3:0];
			end
			if (wr_index == CFG_FRACT) begin
				cfg_q.fract <= fract_sat;
			end
			if (wr_index == CFG_ENABLE) begin
				cfg_q.enable <= wr_data[3:0];
			end
			for (int k = 0; k < SLOTS; k++) begin
				if (wr_index == CFG_IDX_W'(int'(CFG_PERIOD0) + k)) begin
					period_q[k] <= wr_data;
				end
			end
		end
	end

	assign cfg    = cfg_q;
	assign period = period_q;

endmodule

// ===== rtl/mstk_count.sv =====
// Millisecond count, fraction accumulator and tick count.
module mstk_count (
	input  logic                clk,
	input  logic                arst_n,
	input  mstk_pkg::step_t     step,
	input  mstk_pkg::tick_cfg_t cfg,
	output logic [31:0]         ms_cur,
	output logic [31:0]         ms_next,
	output logic [31:0]         ticks_cur,
	output logic [31:0]         ticks_next
);
	import mstk_pkg::*;

	logic [31:0] ms_q;
	logic [31:0] ticks_q;
	logic [6:0]  fract_q;
	logic [7:0]  fract_sum;
	logic        carry;
	logic [6:0]  fract_next;

	always_comb begin
		fract_sum  = {1'b0, fract_q} + {1'b0, cfg.fract};
		carry      = (fract_sum >= {1'b0, FRACT_MOD});
		fract_next = carry ? 7'(fract_sum - {1'b0, FRACT_MOD}) : fract_sum[6:0];
		ms_next    = ms_q + 32'(cfg.whole_ms) + 32'(carry);
		ticks_next = ticks_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q    <= '0;
			ticks_q <= '0;
			fract_q <= '0;
		end else if (step.go && step.func == FUNC_TICK) begin
			ms_q    <= ms_next;
			ticks_q <= ticks_next;
			fract_q <= fract_next;
		end
	end

	assign ms_cur    = ms_q;
	assign ticks_cur = ticks_q;

endmodule

// ===== rtl/mstk_slots.sv =====
// Last-fire times and due compares of the periodic slots.
module mstk_slots #(
	parameter int SLOTS = mstk_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mstk_pkg::step_t step,
	input  logic [3:0]      enable,
	input  logic [31:0]     period [SLOTS],
	input  logic [31:0]     ms_cur,
	input  logic [31:0]     ms_next,
	output logic [3:0]      fire
);
	import mstk_pkg::*;

	logic [31:0] last_q [SLOTS];
	logic [31:0] due    [SLOTS];

	// All slots compare against the post-tick count in parallel; the due sum wraps.
	always_comb begin
		fire = '0;
		for (int k = 0; k < SLOTS; k++) begin
			due[k]  = last_q[k] + period[k];
			fire[k] = (step.func == FUNC_TICK) && enable[k] && (ms_next > due[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				last_q[k] <= '0;
			end
		end else if (step.go) begin
			for (int k = 0; k < SLOTS; k++) begin
				if (fire[k]) begin
					last_q[k] <= ms_next;
				end else if (step.func == FUNC_RESTART && step.slot == 2'(k)) begin
					last_q[k] <= ms_cur;
				end
			end
		end
	end

endmodule

// ===== rtl/millisecond_tick_with_periodic_slots_top.sv =====
// Top level of the millisecond tick counter with periodic slots.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_ready, func, slot           | in
//  result  | out_valid, out_ready, millis_now,        | out
//          | tick_count, fire_mask                    |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One item per cycle while the result is not stalled; each item passes the input register, then the result register.
// The count update and all slot compares sit in the logic between the input
// register and the result register; the millisecond add feeding the compare sets the clock period.
// A stalled result holds; the input register then fills and in_ready drops.
// Reset restores the register defaults and clears all counts and last-fire times.
module millisecond_tick_with_periodic_slots_top #(
	parameter int SLOTS = mstk_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [1:0]                     slot,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    millis_now,
	output logic [31:0]                    tick_count,
	output logic [3:0]                     fire_mask,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mstk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import mstk_pkg::*;

	logic        valid_s1;
	func_e       func_s1;
	logic [1:0]  slot_s1;
	logic        advance;
	step_t       step;
	tick_cfg_t   cfg;
	logic [31:0] period [SLOTS];
	logic [31:0] ms_cur;
	logic [31:0] ms_next;
	logic [31:0] ticks_cur;
	logic [31:0] ticks_next;
	logic [3:0]  fire;
	logic        out_valid_q;
	logic [31:0] millis_q;
	logic [31:0] ticks_q;
	logic [3:0]  fire_q;

	assign cfg_ready = 1'b1;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func_e'(func);
			slot_s1 <= slot;
		end
	end

	always_comb begin
		step.go   = advance;
		step.func = func_s1;
		step.slot = slot_s1;
	end

	mstk_cfg #(
		.SLOTS(SLOTS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg),
		.period  (period)
	);

	mstk_count u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cfg       (cfg),
		.ms_cur    (ms_cur),
		.ms_next   (ms_next),
		.ticks_cur (ticks_cur),
		.ticks_next(ticks_next)
	);

	mstk_slots #(
		.SLOTS(SLOTS)
	) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.enable (cfg.enable),
		.period (period),
		.ms_cur (ms_cur),
		.ms_next(ms_next),
		.fire   (fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A restart reports the unchanged counts and no firing slots.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (func_s1 == FUNC_TICK) begin
				millis_q <= ms_next;
				ticks_q  <= ticks_next;
				fire_q   <= fire;
			end else begin
				millis_q <= ms_cur;
				ticks_q  <= ticks_cur;
				fire_q   <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign millis_now = millis_q;
	assign tick_count = ticks_q;
	assign fire_mask  = fire_q;

endmodule

// ===== rtl/mstk_checker.sv =====
// Port-level checker of the millisecond tick block and its bind.
`include "millisecond_tick_with_periodic_slots_top_macros.svh"

module mstk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] millis_now,
	input logic [31:0] tick_count,
	input logic [3:0]  fire_mask,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// The block only pushes back on its input when a result is waiting and stalled.
	`MSTK_ASSERT_NOW(a_in_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without output stall")

	// A stalled result stays valid and unchanged until its transfer.
	`MSTK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(millis_now) && $stable(tick_count) && $stable(fire_mask), "stalled result changed")

	// Configuration writes are never refused.
	`MSTK_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind millisecond_tick_with_periodic_slots_top mstk_checker u_mstk_checker (.*);
